@@ rtl/core/mgmt_pkg.sv @@
`timescale 1ns / 1ps
package mgmt_pkg;
  localparam int unsigned HandleW = 32;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_LEAVE = 2'd1,
    OP_CAST  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_LISTED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [HandleW-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [HandleW-1:0] member_handle;
    logic               last;
    logic [5:0]         member_count;
    logic [4:0]         unknown_leaves;
  } rsp_t;
endpackage

@@ rtl/core/mgmt_if.sv @@
`timescale 1ns / 1ps
interface mgmt_req_if;
  import mgmt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mgmt_rsp_if;
  import mgmt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mgmt_front.sv @@
`timescale 1ns / 1ps
// Input skid queue: two entries, decouples the port from the engine.
module mgmt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mgmt_pkg::req_t  in_data_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output mgmt_pkg::req_t  q_data_o
);
  import mgmt_pkg::*;

  req_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o && (in_data_i.opcode != OP_NONE);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rp_q];
  assign pop = q_valid_o && q_ready_i;

  always_comb begin
    wp_d = wp_q ^ push;
    rp_d = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end
endmodule

@@ rtl/core/mgmt_engine.sv @@
`timescale 1ns / 1ps
module mgmt_engine #(
  parameter int unsigned MaxMembers = 32,
  parameter int unsigned QueueDepth = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  mgmt_pkg::req_t q_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mgmt_pkg::rsp_t out_data_o
);
  import mgmt_pkg::*;

  localparam int unsigned TW = (MaxMembers > 1) ? $clog2(MaxMembers) : 1;
  localparam int unsigned QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned TCW = $clog2(MaxMembers + 1);
  localparam int unsigned QCW = $clog2(QueueDepth + 1);
  localparam int unsigned BANK = 2;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_INS    = 8'b00000010,
    S_MRD    = 8'b00000100,
    S_MERGE  = 8'b00001000,
    S_LRD    = 8'b00010000,
    S_LEAVE  = 8'b00100000,
    S_LIST   = 8'b01000000,
    S_RESP   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // Table ping-pong banks; merge writes bank sel plus the enter queue to !sel, leave filters it back.
  logic [HandleW-1:0] tab_q [BANK][MaxMembers];
  logic [HandleW-1:0] enq_q [QueueDepth];
  logic [HandleW-1:0] lvq_q [QueueDepth];
  logic               sel_q, sel_d;
  logic [TCW-1:0]     total_q, total_d;
  logic [QCW-1:0]     ecnt_q, ecnt_d, lcnt_q, lcnt_d;

  logic [TCW-1:0]     a_q, a_d, n_q, n_d;
  logic [QCW-1:0]     b_q, b_d, pos_q, pos_d;
  logic               ovf_q, ovf_d, isleave_q, isleave_d;
  logic [4:0]         unk_q, unk_d;
  logic [HandleW-1:0] h_q, h_d, last_v_q, last_v_d;
  logic               have_last_q, have_last_d;

  logic               ovalid_q, ovalid_d;
  rsp_t               odata_q, odata_d;
  logic               out_free;

  // Registered table read, addressed with the next bank and index.
  logic [HandleW-1:0] ta_q;
  logic               tab_we;
  logic [HandleW-1:0] tab_wdata;
  logic               q_we;
  logic [HandleW-1:0] q_wdata;

  logic [HandleW-1:0] ta, qb, prev_e;
  logic               a_ok, b_ok, take_a, lst_item;
  logic [HandleW-1:0] v;
  logic [QW-1:0]      pm1;
  logic [QCW-1:0]     qcnt;
  logic [5:0]         tot6;

  assign out_free = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_data_o = odata_q;
  assign q_ready_o = (state_q == S_IDLE);

  assign ta = ta_q;
  assign qb = isleave_q ? lvq_q[b_q[QW-1:0]] : enq_q[b_q[QW-1:0]];
  assign a_ok = (a_q < total_q);
  assign b_ok = isleave_q ? (b_q < lcnt_q) : (b_q < ecnt_q);
  assign take_a = !b_ok || (a_ok && ta <= qb);
  assign v = take_a ? ta : qb;
  assign pm1 = pos_q[QW-1:0] - 1'b1;
  assign prev_e = isleave_q ? lvq_q[pm1] : enq_q[pm1];
  assign qcnt = isleave_q ? lcnt_q : ecnt_q;
  assign lst_item = (a_q + 1'b1 == total_q);
  assign tot6 = 6'(total_q);

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    ecnt_d = ecnt_q;
    lcnt_d = lcnt_q;
    sel_d = sel_q;
    a_d = a_q;
    n_d = n_q;
    b_d = b_q;
    pos_d = pos_q;
    ovf_d = ovf_q;
    isleave_d = isleave_q;
    unk_d = unk_q;
    h_d = h_q;
    last_v_d = last_v_q;
    have_last_d = have_last_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d = odata_q;
    tab_we = 1'b0;
    tab_wdata = ta;
    q_we = 1'b0;
    q_wdata = h_q;
    case (state_q)
      S_IDLE: if (q_valid_i) begin
        state_d = (q_data_i.opcode == OP_CAST) ? S_MRD : S_INS;
        isleave_d = (q_data_i.opcode == OP_LEAVE);
        h_d = q_data_i.handle;
        a_d = '0;
        b_d = '0;
        n_d = '0;
        ovf_d = 1'b0;
        unk_d = '0;
        have_last_d = 1'b0;
        pos_d = (q_data_i.opcode == OP_LEAVE) ? lcnt_q : ecnt_q;
      end
      S_INS: begin
        // Insertion sort, one shift per cycle.
        if (qcnt >= QCW'(QueueDepth)) begin
          if (out_free) begin
            ovalid_d = 1'b1;
            odata_d = '{ST_FULL, '0, 1'b1, tot6, 5'd0};
            state_d = S_IDLE;
          end
        end else if (pos_q != '0 && prev_e > h_q) begin
          q_we = 1'b1;
          q_wdata = prev_e;
          pos_d = pos_q - 1'b1;
        end else if (out_free) begin
          q_we = 1'b1;
          q_wdata = h_q;
          if (isleave_q) lcnt_d = lcnt_q + 1'b1;
          else ecnt_d = ecnt_q + 1'b1;
          ovalid_d = 1'b1;
          odata_d = '{ST_QUEUED, '0, 1'b1, tot6, 5'd0};
          state_d = S_IDLE;
        end
      end
      S_MRD: state_d = S_MERGE;
      S_MERGE: begin
        if (!(a_ok || b_ok) || ovf_q) begin
          total_d = n_q;
          ecnt_d = '0;
          sel_d = !sel_q;
          isleave_d = 1'b1;
          a_d = '0;
          b_d = '0;
          n_d = '0;
          state_d = S_LRD;
        end else begin
          if (take_a) a_d = a_q + 1'b1;
          else b_d = b_q + 1'b1;
          if (v != '0 && !(have_last_q && last_v_q == v)) begin
            if (n_q >= TCW'(MaxMembers)) begin
              ovf_d = 1'b1;
            end else begin
              tab_we = 1'b1;
              tab_wdata = v;
              n_d = n_q + 1'b1;
              last_v_d = v;
              have_last_d = 1'b1;
            end
          end
        end
      end
      S_LRD: state_d = S_LEAVE;
      S_LEAVE: begin
        if (b_ok) begin
          if (a_ok && ta < qb) begin
            tab_we = 1'b1;
            n_d = n_q + 1'b1;
            a_d = a_q + 1'b1;
          end else begin
            if (a_ok && ta == qb) a_d = a_q + 1'b1;
            else unk_d = unk_q + 1'b1;
            b_d = b_q + 1'b1;
          end
        end else if (a_ok) begin
          tab_we = 1'b1;
          n_d = n_q + 1'b1;
          a_d = a_q + 1'b1;
        end else begin
          total_d = n_q;
          lcnt_d = '0;
          sel_d = !sel_q;
          a_d = '0;
          state_d = (n_q == '0) ? S_RESP : S_LIST;
        end
      end
      S_LIST: if (out_free) begin
        ovalid_d = 1'b1;
        odata_d = '{ovf_q ? ST_OVERFLOW : ST_LISTED, ta, lst_item, tot6, unk_q};
        a_d = a_q + 1'b1;
        if (lst_item) state_d = S_IDLE;
      end
      S_RESP: if (out_free) begin
        ovalid_d = 1'b1;
        odata_d = '{ovf_q ? ST_OVERFLOW : ST_EMPTY, '0, 1'b1, 6'd0, unk_q};
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      ecnt_q <= '0;
      lcnt_q <= '0;
      sel_q <= 1'b0;
      a_q <= '0;
      n_q <= '0;
      b_q <= '0;
      pos_q <= '0;
      ovf_q <= 1'b0;
      isleave_q <= 1'b0;
      unk_q <= '0;
      h_q <= '0;
      last_v_q <= '0;
      have_last_q <= 1'b0;
      ovalid_q <= 1'b0;
      odata_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ecnt_q <= ecnt_d;
      lcnt_q <= lcnt_d;
      sel_q <= sel_d;
      a_q <= a_d;
      n_q <= n_d;
      b_q <= b_d;
      pos_q <= pos_d;
      ovf_q <= ovf_d;
      isleave_q <= isleave_d;
      unk_q <= unk_d;
      h_q <= h_d;
      last_v_q <= last_v_d;
      have_last_q <= have_last_d;
      ovalid_q <= ovalid_d;
      odata_q <= odata_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_q[!sel_q][n_q[TW-1:0]] <= tab_wdata;
    end
    ta_q <= tab_q[sel_d][a_d[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      if (isleave_q) lvq_q[pos_q[QW-1:0]] <= q_wdata;
      else enq_q[pos_q[QW-1:0]] <= q_wdata;
    end
  end
endmodule

@@ rtl/core/multicast_group_membership_table_unit.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Payload
// req      in   opcode, handle
// rsp      out  status, member_handle, last, member_count, unknown_leaves
// Enter/leave: insertion shift into the sorted queue, one entry per cycle.
// Cast: merges members with enters, then filters members by leaves, then lists
// each member in turn, all through the single registered table read port.
// Reset clears control state only; table and queue contents are never read unwritten.
// A two-entry input queue absorbs items while the engine or output stalls.
module multicast_group_membership_table_unit #(
  parameter int unsigned MaxMembers = 32,
  parameter int unsigned QueueDepth = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mgmt_req_if.sink   req,
  mgmt_rsp_if.source rsp
);
  import mgmt_pkg::*;

  logic q_valid, q_ready;
  req_t q_data;

  mgmt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .in_data_i(req.data),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  mgmt_engine #(.MaxMembers(MaxMembers), .QueueDepth(QueueDepth)) u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready), .out_data_o(rsp.data)
  );

`ifndef SYNTH
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.data.status == ST_QUEUED |-> rsp.data.last)
    else $error("queued result without last");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.data.status == ST_EMPTY |-> rsp.data.member_count == 6'd0)
    else $error("empty group with nonzero count");
  a_list_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.data.status == ST_LISTED |-> rsp.data.member_handle != '0)
    else $error("listed member zero");
`endif
endmodule
